>>> src/srs_pkg.sv
// Shared types, constants and fixed-point helpers for the sphere repulsion block.
// No dependencies; imported by the top level, srs_alu and srs_checker (srs_ram does not use it).
package srs_pkg;

  localparam int DEF_MAX_POINTS  = 256;
  localparam int DEF_COORD_WIDTH = 32;

  localparam int IO_W    = 32;
  localparam int IO_FRAC = 28;
  localparam int VAL_W   = 64;
  localparam int WIDE_W  = 128;
  localparam int CFG_W   = 17;

  localparam logic signed [VAL_W-1:0] ACC_LIM   = 64'sh4000_0000_0000_0000;
  localparam logic [31:0]             TENTH_Q32 = 32'd429496730;
  localparam logic [CFG_W-1:0]        GAIN_ONE  = 17'd65536;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_STEP  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  localparam logic REG_POINT_COUNT = 1'b0;
  localparam logic REG_INV_SQRT    = 1'b1;

  localparam logic [1:0] ALU_MUL  = 2'd0;
  localparam logic [1:0] ALU_DIV  = 2'd1;
  localparam logic [1:0] ALU_SQRT = 2'd2;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [WIDE_W-1:0]       wide_t;

  typedef struct packed {
    logic       go;
    logic [1:0] op;
  } alu_req_t;

  function automatic logic [VAL_W-1:0] mag(input val_t a);
    return a[VAL_W-1] ? VAL_W'(-a) : VAL_W'(a);
  endfunction

  // signed value from a magnitude, saturated at +-2^62
  function automatic val_t sat_mag(input logic neg, input wide_t m);
    val_t v;
    v = (m > WIDE_W'(ACC_LIM)) ? ACC_LIM : val_t'(m[VAL_W-1:0]);
    return neg ? -v : v;
  endfunction

  function automatic val_t sat_add(input val_t a, input val_t b);
    logic signed [VAL_W:0] s;
    s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
    if (s > (VAL_W+1)'(ACC_LIM)) return ACC_LIM;
    if (s < -((VAL_W+1)'(ACC_LIM))) return -ACC_LIM;
    return s[VAL_W-1:0];
  endfunction

endpackage

>>> src/sphere_point_repulsion_step.sv
// Sphere point repulsion block: point/velocity stores, step sequencer, one shared ALU.
// Depends on srs_pkg, srs_ram and srs_alu.
//
// Write and no-operation words give their result in the cycle after they are accepted; a read
// first passes through the registered store read and the S_RD state. A step keeps busy high
// while every arithmetic operation runs on the single bit-serial unit, and each ordered point
// pair needs three squares, one root and six divides. After reset busy stays high while the
// velocity store is cleared. Results appear for one cycle with result_valid and cannot be
// held off; configuration may be written at any time the block is idle.
module sphere_point_repulsion_step #(
  parameter int MAX_POINTS  = srs_pkg::DEF_MAX_POINTS,
  parameter int COORD_WIDTH = srs_pkg::DEF_COORD_WIDTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         operation,
  input  logic [7:0]         index,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  output logic               result_valid,
  output logic [7:0]         out_index,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic               step_done,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [16:0]        cfg_data
);
  import srs_pkg::*;

  localparam int CW     = COORD_WIDTH;
  localparam int FRAC   = CW - 4;
  localparam int UP     = (FRAC >= IO_FRAC) ? FRAC - IO_FRAC : 0;
  localparam int DN     = (FRAC < IO_FRAC) ? IO_FRAC - FRAC : 0;
  localparam int ADDR_W = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int ROW_W  = 3 * CW;
  localparam logic signed [63:0] CMAX = (64'sd1 <<< (CW - 1)) - 64'sd1;
  localparam logic signed [63:0] CMIN = -CMAX - 64'sd1;

  localparam logic [5:0] S_IDLE    = 6'd0;
  localparam logic [5:0] S_CLR     = 6'd1;
  localparam logic [5:0] S_RD      = 6'd2;
  localparam logic [5:0] S_ST_INIT = 6'd3;
  localparam logic [5:0] S_PI_RD   = 6'd4;
  localparam logic [5:0] S_PI_LD   = 6'd5;
  localparam logic [5:0] S_PJ_RD   = 6'd6;
  localparam logic [5:0] S_PJ_LD   = 6'd7;
  localparam logic [5:0] S_SQ      = 6'd8;
  localparam logic [5:0] S_SQ_W    = 6'd9;
  localparam logic [5:0] S_RT      = 6'd10;
  localparam logic [5:0] S_RT_W    = 6'd11;
  localparam logic [5:0] S_D1      = 6'd12;
  localparam logic [5:0] S_D1_W    = 6'd13;
  localparam logic [5:0] S_D2      = 6'd14;
  localparam logic [5:0] S_D2_W    = 6'd15;
  localparam logic [5:0] S_K       = 6'd16;
  localparam logic [5:0] S_K_W     = 6'd17;
  localparam logic [5:0] S_DOT     = 6'd18;
  localparam logic [5:0] S_DOT_W   = 6'd19;
  localparam logic [5:0] S_PR      = 6'd20;
  localparam logic [5:0] S_PR_W    = 6'd21;
  localparam logic [5:0] S_G       = 6'd22;
  localparam logic [5:0] S_G_W     = 6'd23;
  localparam logic [5:0] S_VW      = 6'd24;
  localparam logic [5:0] S_MV_RD   = 6'd25;
  localparam logic [5:0] S_MV_LD   = 6'd26;
  localparam logic [5:0] S_MQ      = 6'd27;
  localparam logic [5:0] S_MQ_W    = 6'd28;
  localparam logic [5:0] S_ML      = 6'd29;
  localparam logic [5:0] S_ML_W    = 6'd30;
  localparam logic [5:0] S_MD      = 6'd31;
  localparam logic [5:0] S_MD_W    = 6'd32;
  localparam logic [5:0] S_MW      = 6'd33;
  localparam logic [5:0] S_FIN     = 6'd34;

  function automatic val_t sx(input logic [CW-1:0] v);
    return {{(64-CW){v[CW-1]}}, v};
  endfunction

  function automatic logic [CW-1:0] clampc(input val_t v);
    val_t t;
    t = (v > CMAX) ? CMAX : ((v < CMIN) ? CMIN : v);
    return t[CW-1:0];
  endfunction

  function automatic logic [CW-1:0] from_io(input logic [31:0] x);
    val_t t;
    t = {{32{x[31]}}, x};
    t = (t <<< UP) >>> DN;
    return clampc(t);
  endfunction

  function automatic logic [31:0] to_io(input logic [CW-1:0] v);
    val_t t;
    t = (sx(v) <<< DN) >>> UP;
    if (t > 64'sd2147483647) return 32'h7fff_ffff;
    if (t < -64'sd2147483648) return 32'h8000_0000;
    return t[31:0];
  endfunction

  // configuration
  logic [8:0]  point_count;
  logic [16:0] inv_sqrt_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count    <= 9'd1;
      inv_sqrt_count <= GAIN_ONE;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_POINT_COUNT: point_count    <= cfg_data[8:0];
        REG_INV_SQRT:    inv_sqrt_count <= cfg_data;
        default:         point_count    <= point_count;
      endcase
    end
  end

  logic [CNT_W-1:0] cnt_sat;
  logic [16:0]      g_sat;
  logic [48:0]      k1_full;

  always_comb begin
    cnt_sat = (32'(point_count) > MAX_POINTS) ? CNT_W'(MAX_POINTS) : CNT_W'(point_count);
    g_sat   = (inv_sqrt_count > GAIN_ONE) ? GAIN_ONE : inv_sqrt_count;
    k1_full = 49'(g_sat) * 49'(TENTH_Q32);
  end

  // state
  logic [5:0]       state;
  logic [CNT_W-1:0] i;
  logic [CNT_W-1:0] j;
  logic [CNT_W-1:0] cnt_r;
  logic [1:0]       c;
  logic [16:0]      g_r;
  logic [63:0]      k1;
  logic [7:0]       idx_r;
  logic             idx_ok_r;
  logic [CW-1:0]    pi [3];
  logic [CW-1:0]    vi [3];
  logic [CW-1:0]    w [3];
  logic [CW-1:0]    vnew [3];
  val_t             d [3];
  val_t             f [3];
  val_t             t;
  val_t             dot;
  wide_t            sq_acc;
  logic [63:0]      s;
  logic [63:0]      r;

  logic accept;
  logic idx_ok;
  assign accept = start && !busy;
  assign idx_ok = 32'(index) < MAX_POINTS;
  assign busy   = state != S_IDLE;

  // stores
  logic              p_we, v_we;
  logic [ADDR_W-1:0] p_waddr, v_waddr, p_raddr, v_raddr;
  logic [ROW_W-1:0]  p_wdata, v_wdata, p_rdata, v_rdata;
  logic [CW-1:0]     fx, fy, fz;

  assign fx = from_io(pos_x);
  assign fy = from_io(pos_y);
  assign fz = from_io(pos_z);

  srs_ram #(.WIDTH(ROW_W), .DEPTH(MAX_POINTS)) u_point_ram (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata), .raddr(p_raddr), .rdata(p_rdata)
  );

  srs_ram #(.WIDTH(ROW_W), .DEPTH(MAX_POINTS)) u_vel_ram (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata), .raddr(v_raddr), .rdata(v_rdata)
  );

  always_comb begin
    p_we    = 1'b0;
    v_we    = 1'b0;
    p_waddr = i[ADDR_W-1:0];
    v_waddr = i[ADDR_W-1:0];
    p_wdata = {vnew[2], vnew[1], vnew[0]};
    v_wdata = {vnew[2], vnew[1], vnew[0]};
    p_raddr = i[ADDR_W-1:0];
    v_raddr = i[ADDR_W-1:0];
    case (state)
      S_IDLE: begin
        p_raddr = ADDR_W'(index);
        if (accept && operation == OP_WRITE && idx_ok) begin
          p_we    = 1'b1;
          v_we    = 1'b1;
          p_waddr = ADDR_W'(index);
          v_waddr = ADDR_W'(index);
          p_wdata = {fz, fy, fx};
          v_wdata = '0;
        end
      end
      S_CLR: begin
        v_we    = 1'b1;
        v_wdata = '0;
      end
      S_PJ_RD: p_raddr = j[ADDR_W-1:0];
      S_VW:    v_we = 1'b1;
      S_MW:    p_we = 1'b1;
      default: p_we = 1'b0;
    endcase
  end

  // shared unit
  alu_req_t    alu_req;
  logic [63:0] alu_a, alu_b;
  wide_t       alu_n;
  logic        alu_done;
  wide_t       alu_res;
  wide_t       sq_sh;
  logic [63:0] s_calc;

  always_comb begin
    sq_sh  = sq_acc >> FRAC;
    s_calc = (sq_sh[127:64] != '0) ? {64{1'b1}} : sq_sh[63:0];
    if (s_calc == '0) s_calc = 64'd1 << FRAC;
  end

  always_comb begin
    alu_req.go = 1'b0;
    alu_req.op = ALU_MUL;
    alu_a      = mag(d[c]);
    alu_b      = mag(d[c]);
    alu_n      = 128'(mag(d[c])) << FRAC;
    case (state)
      S_SQ, S_MQ: alu_req.go = 1'b1;
      S_RT: begin
        alu_req = '{go: 1'b1, op: ALU_SQRT};
        alu_n   = 128'(s_calc) << FRAC;
      end
      S_D1: begin
        alu_req = '{go: 1'b1, op: ALU_DIV};
        alu_b   = s;
      end
      S_D2: begin
        alu_req = '{go: 1'b1, op: ALU_DIV};
        alu_n   = 128'(mag(t)) << FRAC;
        alu_b   = r;
      end
      S_K: begin
        alu_req.go = 1'b1;
        alu_a      = mag(f[c]);
        alu_b      = k1;
      end
      S_DOT: begin
        alu_req.go = 1'b1;
        alu_a      = mag(sx(pi[c]));
        alu_b      = mag(sx(w[c]));
      end
      S_PR: begin
        alu_req.go = 1'b1;
        alu_a      = mag(dot);
        alu_b      = mag(sx(pi[c]));
      end
      S_G: begin
        alu_req.go = 1'b1;
        alu_b      = 64'(g_r);
      end
      S_ML: begin
        alu_req = '{go: 1'b1, op: ALU_SQRT};
        alu_n   = sq_acc;
      end
      S_MD: begin
        alu_req = '{go: 1'b1, op: ALU_DIV};
        alu_b   = r;
      end
      default: alu_req.go = 1'b0;
    endcase
  end

  srs_alu u_alu (
    .clk(clk), .rst(rst), .req(alu_req), .a(alu_a), .b(alu_b), .n(alu_n),
    .done(alu_done), .res(alu_res)
  );

  logic last_c;
  assign last_c = c == 2'd2;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLR;
      i            <= '0;
      result_valid <= 1'b0;
      step_done    <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      step_done    <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            idx_r    <= index;
            idx_ok_r <= idx_ok;
            case (operation)
              OP_STEP: state <= S_ST_INIT;
              OP_READ: state <= S_RD;
              OP_WRITE: begin
                result_valid <= 1'b1;
                out_index    <= index;
                out_x        <= idx_ok ? to_io(fx) : '0;
                out_y        <= idx_ok ? to_io(fy) : '0;
                out_z        <= idx_ok ? to_io(fz) : '0;
              end
              default: begin
                result_valid <= 1'b1;
                out_index    <= index;
                out_x        <= '0;
                out_y        <= '0;
                out_z        <= '0;
              end
            endcase
          end
        end
        S_CLR: begin
          i <= i + 1'b1;
          if (i == CNT_W'(MAX_POINTS - 1)) state <= S_IDLE;
        end
        S_RD: begin
          result_valid <= 1'b1;
          out_index    <= idx_r;
          out_x        <= idx_ok_r ? to_io(p_rdata[0 +: CW]) : '0;
          out_y        <= idx_ok_r ? to_io(p_rdata[CW +: CW]) : '0;
          out_z        <= idx_ok_r ? to_io(p_rdata[2*CW +: CW]) : '0;
          state        <= S_IDLE;
        end
        S_ST_INIT: begin
          cnt_r <= cnt_sat;
          g_r   <= g_sat;
          k1    <= 64'(k1_full);
          i     <= '0;
          state <= (cnt_sat == '0) ? S_FIN : S_PI_RD;
        end
        S_PI_RD: state <= S_PI_LD;
        S_PI_LD: begin
          for (int k = 0; k < 3; k++) begin
            pi[k] <= p_rdata[k*CW +: CW];
            vi[k] <= v_rdata[k*CW +: CW];
            f[k]  <= '0;
          end
          j     <= '0;
          state <= S_PJ_RD;
        end
        S_PJ_RD: state <= S_PJ_LD;
        S_PJ_LD: begin
          for (int k = 0; k < 3; k++) begin
            d[k] <= sx(p_rdata[k*CW +: CW]) - sx(pi[k]);
          end
          sq_acc <= '0;
          c      <= '0;
          state  <= S_SQ;
        end
        S_SQ: state <= S_SQ_W;
        S_SQ_W: begin
          if (alu_done) begin
            sq_acc <= sq_acc + alu_res;
            c      <= last_c ? 2'd0 : c + 2'd1;
            state  <= last_c ? S_RT : S_SQ;
          end
        end
        S_RT: begin
          s     <= s_calc;
          state <= S_RT_W;
        end
        S_RT_W: begin
          if (alu_done) begin
            r     <= alu_res[63:0];
            state <= S_D1;
          end
        end
        S_D1: state <= S_D1_W;
        S_D1_W: begin
          if (alu_done) begin
            t     <= sat_mag(d[c][63], {64'd0, alu_res[63:0]});
            state <= S_D2;
          end
        end
        S_D2: state <= S_D2_W;
        S_D2_W: begin
          if (alu_done) begin
            f[c] <= sat_add(f[c], sat_mag(t[63], {64'd0, alu_res[63:0]}));
            if (!last_c) begin
              c     <= c + 2'd1;
              state <= S_D1;
            end else if (j == cnt_r - 1'b1) begin
              c     <= '0;
              state <= S_K;
            end else begin
              j     <= j + 1'b1;
              state <= S_PJ_RD;
            end
          end
        end
        S_K: state <= S_K_W;
        S_K_W: begin
          if (alu_done) begin
            w[c]  <= clampc(sx(vi[c]) - sat_mag(f[c][63], alu_res >> 48));
            c     <= last_c ? 2'd0 : c + 2'd1;
            dot   <= '0;
            state <= last_c ? S_DOT : S_K;
          end
        end
        S_DOT: state <= S_DOT_W;
        S_DOT_W: begin
          if (alu_done) begin
            dot   <= dot + sat_mag(pi[c][CW-1] ^ w[c][CW-1], alu_res >> FRAC);
            c     <= last_c ? 2'd0 : c + 2'd1;
            state <= last_c ? S_PR : S_DOT;
          end
        end
        S_PR: state <= S_PR_W;
        S_PR_W: begin
          if (alu_done) begin
            d[c]  <= sx(w[c]) - sat_mag(dot[63] ^ pi[c][CW-1], alu_res >> FRAC);
            c     <= last_c ? 2'd0 : c + 2'd1;
            state <= last_c ? S_G : S_PR;
          end
        end
        S_G: state <= S_G_W;
        S_G_W: begin
          if (alu_done) begin
            vnew[c] <= clampc(sat_mag(d[c][63], alu_res >> 17));
            c       <= last_c ? 2'd0 : c + 2'd1;
            state   <= last_c ? S_VW : S_G;
          end
        end
        S_VW: begin
          if (i == cnt_r - 1'b1) begin
            i     <= '0;
            state <= S_MV_RD;
          end else begin
            i     <= i + 1'b1;
            state <= S_PI_RD;
          end
        end
        S_MV_RD: state <= S_MV_LD;
        S_MV_LD: begin
          for (int k = 0; k < 3; k++) begin
            d[k] <= sx(p_rdata[k*CW +: CW]) + sx(v_rdata[k*CW +: CW]);
          end
          sq_acc <= '0;
          c      <= '0;
          state  <= S_MQ;
        end
        S_MQ: state <= S_MQ_W;
        S_MQ_W: begin
          if (alu_done) begin
            sq_acc <= sq_acc + alu_res;
            c      <= last_c ? 2'd0 : c + 2'd1;
            state  <= last_c ? S_ML : S_MQ;
          end
        end
        S_ML: state <= S_ML_W;
        S_ML_W: begin
          if (alu_done) begin
            r <= alu_res[63:0];
            if (alu_res[63:0] == '0) begin
              for (int k = 0; k < 3; k++) begin
                vnew[k] <= d[k][CW-1:0];
              end
              state <= S_MW;
            end else begin
              state <= S_MD;
            end
          end
        end
        S_MD: state <= S_MD_W;
        S_MD_W: begin
          if (alu_done) begin
            vnew[c] <= clampc(sat_mag(d[c][63], {64'd0, alu_res[63:0]}));
            c       <= last_c ? 2'd0 : c + 2'd1;
            state   <= last_c ? S_MW : S_MD;
          end
        end
        S_MW: begin
          if (i == cnt_r - 1'b1) begin
            state <= S_FIN;
          end else begin
            i     <= i + 1'b1;
            state <= S_MV_RD;
          end
        end
        S_FIN: begin
          result_valid <= 1'b1;
          step_done    <= 1'b1;
          out_index    <= '0;
          out_x        <= '0;
          out_y        <= '0;
          out_z        <= '0;
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> src/srs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module srs_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> src/srs_alu.sv
// Shared bit-serial arithmetic unit: 64x64 multiply, 128/64 divide, 128-bit square root.
// One result bit per cycle. Depends on srs_pkg.
module srs_alu (
  input  logic              clk,
  input  logic              rst,
  input  srs_pkg::alu_req_t req,
  input  logic [63:0]       a,
  input  logic [63:0]       b,
  input  logic [127:0]      n,
  output logic              done,
  output logic [127:0]      res
);
  import srs_pkg::*;

  logic         busy;
  logic [1:0]   op_r;
  logic [5:0]   cnt;
  logic [127:0] acc;
  logic [63:0]  ma;
  logic [63:0]  mb;
  logic [127:0] xr;
  logic [65:0]  rem;

  logic [64:0]  div_r2;
  logic         div_ge;
  logic [65:0]  sq_r2;
  logic [65:0]  sq_trial;
  logic         sq_ge;

  always_comb begin
    div_r2   = {rem[63:0], xr[127]};
    div_ge   = div_r2 >= {1'b0, mb};
    sq_r2    = {rem[63:0], xr[127:126]};
    sq_trial = {acc[63:0], 2'b01};
    sq_ge    = sq_r2 >= sq_trial;
  end

  assign res = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        op_r <= req.op;
        cnt  <= '0;
        acc  <= '0;
        ma   <= a;
        mb   <= b;
        xr   <= (req.op == ALU_DIV) ? {n[63:0], 64'd0} : n;
        rem  <= (req.op == ALU_DIV) ? {2'b00, n[127:64]} : '0;
        busy <= 1'b1;
        if (req.op == ALU_DIV && (b == '0 || n[127:64] >= b)) begin
          acc  <= {64'd0, {64{1'b1}}};
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (busy) begin
        case (op_r)
          ALU_MUL: begin
            acc <= {acc[126:0], 1'b0} + (mb[63] ? {64'd0, ma} : 128'd0);
            mb  <= {mb[62:0], 1'b0};
          end
          ALU_DIV: begin
            rem <= div_ge ? {1'b0, div_r2 - {1'b0, mb}} : {1'b0, div_r2};
            acc <= {acc[126:0], div_ge};
            xr  <= {xr[126:0], 1'b0};
          end
          ALU_SQRT: begin
            rem <= sq_ge ? (sq_r2 - sq_trial) : sq_r2;
            acc <= {acc[126:0], sq_ge};
            xr  <= {xr[125:0], 2'b00};
          end
          default: begin
            acc <= acc;
          end
        endcase
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

>>> src/srs_checker.sv
// Port-level checks for the sphere repulsion block, bound to the top level.
// Depends on srs_pkg and sphere_point_repulsion_step.
module srs_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic [1:0]         operation,
  input logic [7:0]         index,
  input logic signed [31:0] pos_x,
  input logic signed [31:0] pos_y,
  input logic signed [31:0] pos_z,
  input logic               result_valid,
  input logic [7:0]         out_index,
  input logic signed [31:0] out_x,
  input logic signed [31:0] out_y,
  input logic signed [31:0] out_z,
  input logic               step_done,
  input logic               cfg_write,
  input logic               cfg_index,
  input logic [16:0]        cfg_data
);
  import srs_pkg::*;

  a_clear_after_reset: assert property (@(posedge clk) rst |=> busy)
    else $error("not busy after reset");

  a_step_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && operation == OP_STEP) |=> busy)
    else $error("step word did not raise busy");

  a_write_word: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && operation == OP_WRITE) |=> (result_valid && !step_done
      && out_index == $past(index)))
    else $error("write word gave no result");

  a_step_result: assert property (@(posedge clk) disable iff (rst)
    step_done |-> (result_valid && out_index == 8'd0 && out_x == 32'sd0
      && out_y == 32'sd0 && out_z == 32'sd0))
    else $error("bad step result word");
endmodule

bind sphere_point_repulsion_step srs_checker u_srs_checker (.*);
